// File: rtl/rmcd_pkg.sv
// Shared types, constants and the key table of the content-length framing detector.
package rmcd_pkg;

    localparam int DEFAULT_LENGTH_BITS = 32;
    localparam int QUEUE_DEPTH         = 4;
    localparam int KEY_LEN             = 14;
    localparam int KEY_POS_BITS        = 4;
    localparam int OUT_LENGTH_BITS     = 32;

    localparam logic [1:0] ST_SEARCH = 2'd0;
    localparam logic [1:0] ST_VALID  = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;

    typedef struct packed {
        logic       start;
        logic [7:0] lower;
        logic [3:0] digit;
        logic       is_digit;
        logic       is_space;
        logic       is_cr;
        logic       is_lf;
        logic       is_colon;
        logic       is_plus;
        logic       is_minus;
    } t_item;

    function automatic logic [7:0] key_char(input logic [KEY_POS_BITS-1:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/rmcd_front.sv
// Front stage: accept input beats and classify each byte into a registered item.
module rmcd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_data_byte,
    input  logic           i_start_req,
    output logic           o_item_valid,
    input  logic           i_item_ready,
    output rmcd_pkg::t_item o_item
);
    import rmcd_pkg::*;

    logic  r_fv;
    t_item r_item;
    t_item n_item;
    logic  take;

    assign o_ready      = !r_fv || i_item_ready;
    assign take         = i_valid && o_ready;
    assign o_item_valid = r_fv;
    assign o_item       = r_item;

    always_comb begin
        n_item.start    = i_start_req;
        n_item.lower    = (i_data_byte >= "A" && i_data_byte <= "Z") ?
                          (i_data_byte + 8'd32) : i_data_byte;
        n_item.digit    = 4'(i_data_byte - "0");
        n_item.is_digit = (i_data_byte >= "0" && i_data_byte <= "9");
        n_item.is_space = (i_data_byte == 8'h20) ||
                          (i_data_byte >= 8'h09 && i_data_byte <= 8'h0D);
        n_item.is_cr    = (i_data_byte == 8'h0D);
        n_item.is_lf    = (i_data_byte == 8'h0A);
        n_item.is_colon = (i_data_byte == ":");
        n_item.is_plus  = (i_data_byte == "+");
        n_item.is_minus = (i_data_byte == "-");
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (o_ready) begin
            r_fv <= i_valid;
        end
        if (take) begin
            r_item <= n_item;
        end
    end

endmodule

// File: rtl/rmcd_queue.sv
// Short item queue between the front and back stages.
module rmcd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  rmcd_pkg::t_item i_item,
    output logic            o_pop_valid,
    input  logic            i_pop,
    output rmcd_pkg::t_item o_item
);
    import rmcd_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_item               r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_count != CNT_BITS'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_item       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue empty with pointers apart");

endmodule

// File: rtl/rmcd_back.sv
// Back stage: header parser, length decoder, payload counter and output register.
module rmcd_back #(
    parameter int LENGTH_BITS = rmcd_pkg::DEFAULT_LENGTH_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_item_valid,
    output logic                                o_item_pop,
    input  rmcd_pkg::t_item                     i_item,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_header_done,
    output logic [1:0]                          o_length_status,
    output logic [rmcd_pkg::OUT_LENGTH_BITS-1:0] o_declared_length,
    output logic                                o_complete
);
    import rmcd_pkg::*;

    typedef enum logic [2:0] {
        PH_KLEAD, PH_KEY, PH_KTAIL, PH_SKIP, PH_VLEAD, PH_VSIGN, PH_VDIG, PH_DONE
    } t_phase;

    localparam int WIDE_BITS = LENGTH_BITS + 4;

    logic [1:0]              r_crlf,   n_crlf,   c_crlf;
    logic                    r_prevlf, n_prevlf, c_prevlf;
    logic                    r_hdr,    n_hdr,    c_hdr;
    t_phase                  r_phase,  n_phase,  c_phase;
    logic [KEY_POS_BITS-1:0] r_kpos,   n_kpos,   c_kpos;
    logic                    r_neg,    n_neg,    c_neg;
    logic [LENGTH_BITS-1:0]  r_len,    n_len,    c_len;
    logic [1:0]              r_status, n_status, c_status;
    logic [LENGTH_BITS-1:0]  r_cnt,    n_cnt,    c_cnt;

    logic                    r_out_valid;
    logic                    r_o_hdr;
    logic [1:0]              r_o_status;
    logic [OUT_LENGTH_BITS-1:0] r_o_len;
    logic                    r_o_cmp;

    logic [WIDE_BITS-1:0]    wide;
    logic                    ovf;
    logic                    key_hit;
    logic                    key_full;
    logic                    n_valid_len;

    assign o_item_pop        = i_item_valid && (!r_out_valid || i_ready);
    assign o_valid           = r_out_valid;
    assign o_header_done     = r_o_hdr;
    assign o_length_status   = r_o_status;
    assign o_declared_length = r_o_len;
    assign o_complete        = r_o_cmp;

    always_comb begin
        if (i_item.start) begin
            c_crlf   = '0;
            c_prevlf = 1'b0;
            c_hdr    = 1'b0;
            c_phase  = PH_KLEAD;
            c_kpos   = '0;
            c_neg    = 1'b0;
            c_len    = '0;
            c_status = ST_SEARCH;
            c_cnt    = '0;
        end else begin
            c_crlf   = r_crlf;
            c_prevlf = r_prevlf;
            c_hdr    = r_hdr;
            c_phase  = r_phase;
            c_kpos   = r_kpos;
            c_neg    = r_neg;
            c_len    = r_len;
            c_status = r_status;
            c_cnt    = r_cnt;
        end

        wide     = (WIDE_BITS'(c_len) << 3) + (WIDE_BITS'(c_len) << 1) +
                   WIDE_BITS'(i_item.digit);
        ovf      = (wide[WIDE_BITS-1:LENGTH_BITS] != '0);
        key_full = (c_kpos == KEY_POS_BITS'(KEY_LEN));
        key_hit  = (c_kpos < KEY_POS_BITS'(KEY_LEN)) && (i_item.lower == key_char(c_kpos));

        n_crlf   = c_crlf;
        n_prevlf = c_prevlf;
        n_hdr    = c_hdr;
        n_phase  = c_phase;
        n_kpos   = c_kpos;
        n_neg    = c_neg;
        n_len    = c_len;
        n_status = c_status;
        n_cnt    = c_cnt;

        if (c_hdr) begin
            if (c_cnt != '1) begin
                n_cnt = c_cnt + 1'b1;
            end
        end else begin
            if (c_phase != PH_DONE) begin
                if (i_item.is_lf) begin
                    if (c_phase == PH_VLEAD || c_phase == PH_VSIGN || c_phase == PH_VDIG) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_KLEAD;
                        n_kpos  = '0;
                    end
                end else begin
                    case (c_phase)
                        PH_KLEAD: begin
                            if (!i_item.is_space) begin
                                if (!i_item.is_colon && i_item.lower == key_char('0)) begin
                                    n_kpos  = KEY_POS_BITS'(1);
                                    n_phase = PH_KEY;
                                end else begin
                                    n_phase = PH_SKIP;
                                end
                            end
                        end
                        PH_KEY: begin
                            if (i_item.is_colon) begin
                                if (key_full) begin
                                    n_phase  = PH_VLEAD;
                                    n_status = ST_BAD;
                                    n_len    = '0;
                                end else begin
                                    n_phase = PH_SKIP;
                                end
                            end else if (i_item.is_space) begin
                                n_phase = key_full ? PH_KTAIL : PH_SKIP;
                            end else if (key_hit) begin
                                n_kpos = c_kpos + 1'b1;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end
                        PH_KTAIL: begin
                            if (i_item.is_colon) begin
                                n_phase  = PH_VLEAD;
                                n_status = ST_BAD;
                                n_len    = '0;
                            end else if (!i_item.is_space) begin
                                n_phase = PH_SKIP;
                            end
                        end
                        PH_SKIP: begin
                            n_phase = PH_SKIP;
                        end
                        default: begin
                            if (c_phase == PH_VLEAD && i_item.is_space) begin
                                n_phase = PH_VLEAD;
                            end else if (c_phase == PH_VLEAD &&
                                         (i_item.is_plus || i_item.is_minus)) begin
                                n_neg   = i_item.is_minus;
                                n_phase = PH_VSIGN;
                            end else if (i_item.is_digit) begin
                                if (ovf || (c_neg && wide[LENGTH_BITS-1:0] != '0)) begin
                                    n_status = ST_BAD;
                                    n_len    = '0;
                                    n_phase  = PH_DONE;
                                end else begin
                                    n_len    = wide[LENGTH_BITS-1:0];
                                    n_status = ST_VALID;
                                    n_phase  = PH_VDIG;
                                end
                            end else if (c_phase == PH_VDIG) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_status = ST_BAD;
                                n_len    = '0;
                                n_phase  = PH_DONE;
                            end
                        end
                    endcase
                end
            end

            if (i_item.is_cr) begin
                n_crlf = (c_crlf == 2'd2) ? 2'd3 : 2'd1;
            end else if (i_item.is_lf) begin
                if (c_crlf == 2'd3 || c_prevlf) begin
                    n_hdr = 1'b1;
                end
                n_crlf = (c_crlf == 2'd1) ? 2'd2 : 2'd0;
            end else begin
                n_crlf = 2'd0;
            end
            n_prevlf = i_item.is_lf;
        end

        n_valid_len = (n_status == ST_VALID);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crlf      <= '0;
            r_prevlf    <= 1'b0;
            r_hdr       <= 1'b0;
            r_phase     <= PH_KLEAD;
            r_kpos      <= '0;
            r_neg       <= 1'b0;
            r_len       <= '0;
            r_status    <= ST_SEARCH;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_item_pop) begin
                r_crlf   <= n_crlf;
                r_prevlf <= n_prevlf;
                r_hdr    <= n_hdr;
                r_phase  <= n_phase;
                r_kpos   <= n_kpos;
                r_neg    <= n_neg;
                r_len    <= n_len;
                r_status <= n_status;
                r_cnt    <= n_cnt;
            end
            if (!r_out_valid || i_ready) begin
                r_out_valid <= i_item_valid;
            end
        end
        if (o_item_pop) begin
            r_o_hdr    <= n_hdr;
            r_o_status <= n_status;
            r_o_len    <= n_valid_len ? OUT_LENGTH_BITS'(n_len) : '0;
            r_o_cmp    <= n_hdr && n_valid_len && (n_cnt >= n_len);
        end
    end

    a_complete_needs_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_cmp) |-> (r_o_hdr && r_o_status == ST_VALID))
        else $error("complete without header end and valid length");

    a_len_zero_unless_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_status != ST_VALID) |-> (r_o_len == '0))
        else $error("declared length nonzero without valid status");

endmodule

// File: rtl/rtsp_message_completeness_detector.sv
// Top level of the content-length framing detector for text-protocol responses.
//
// Input channel: i_valid / o_ready carry one beat per byte (i_data_byte) with
// i_start_req marking the first byte of a new message, which clears all parse
// state before that byte is taken.
// Output channel: o_valid / i_ready carry one result beat per input beat, in
// order: o_header_done, o_length_status (0 searching or absent, 1 valid,
// 2 bad), o_declared_length (zero unless valid) and o_complete.
// Each result is registered in the classifier stage, the queue and the back
// stage's output register in turn. Throughput: one byte per cycle while the
// output side is not stalled; the parse and count update are combinational.
// A four-beat queue between the classifier stage and the parser lets the
// input keep flowing for several beats while the receiver stalls; once it
// fills, o_ready drops until results are taken.
// Reset: i_rst_n low on a rising edge empties the pipeline and returns the
// parser to the start-of-message state; no clearing pass is needed.
module rtsp_message_completeness_detector #(
    parameter int LENGTH_BITS = rmcd_pkg::DEFAULT_LENGTH_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_start_req,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_header_done,
    output logic [1:0]                          o_length_status,
    output logic [rmcd_pkg::OUT_LENGTH_BITS-1:0] o_declared_length,
    output logic                                o_complete
);
    import rmcd_pkg::*;

    logic  f_valid;
    logic  f_ready;
    t_item f_item;
    logic  q_valid;
    logic  q_pop;
    t_item q_item;

    rmcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_start_req  (i_start_req),
        .o_item_valid (f_valid),
        .i_item_ready (f_ready),
        .o_item       (f_item)
    );

    rmcd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_item       (f_item),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_item       (q_item)
    );

    rmcd_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item_valid      (q_valid),
        .o_item_pop        (q_pop),
        .i_item            (q_item),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_header_done     (o_header_done),
        .o_length_status   (o_length_status),
        .o_declared_length (o_declared_length),
        .o_complete        (o_complete)
    );

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the content-length framing detector.
`timescale 1ns / 1ps

module testbench;
    import rmcd_pkg::*;

    localparam logic [63:0] LEN_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - DEFAULT_LENGTH_BITS);
    localparam logic [7:0]  CR_B = 8'h0d;
    localparam logic [7:0]  LF_B = 8'h0a;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          HOLD_CYCLES    = 60;
    localparam int          HOLD_AFTER     = 200;
    localparam int          TARGET_BYTES   = 700;

    typedef enum logic [2:0] {
        PH_KLEAD, PH_KEY, PH_KTAIL, PH_SKIP, PH_VLEAD, PH_VSIGN, PH_VDIG, PH_DONE
    } t_line_phase;

    typedef struct {
        logic [7:0] data;
        logic       start;
    } t_text_beat;

    typedef struct packed {
        logic        hdr;
        logic [1:0]  status;
        logic [31:0] length;
        logic        done;
    } t_framing;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_start_req = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_header_done;
    logic [1:0]  o_length_status;
    logic [OUT_LENGTH_BITS-1:0] o_declared_length;
    logic        o_complete;

    t_text_beat  byte_q[$];
    t_framing    framing_q[$];
    t_framing    got;
    t_framing    want;
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    int          results_seen = 0;
    bit          msg_head = 1'b0;

    bit          in_beat = 1'b0;
    bit          out_beat = 1'b0;
    int          tx_wait = 0;
    int          rx_wait = 0;
    int          rx_draw;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;

    // predictor state
    logic [1:0]  term_run;
    bit          last_lf;
    bit          hdr_seen;
    t_line_phase phase;
    logic [3:0]  key_pos;
    bit          neg_value;
    logic [63:0] len_acc;
    logic [1:0]  len_status;
    logic [63:0] body_count;
    string       key_word = "content-length";

    rtsp_message_completeness_detector DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_data_byte       (i_data_byte),
        .i_start_req       (i_start_req),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_header_done     (o_header_done),
        .o_length_status   (o_length_status),
        .o_declared_length (o_declared_length),
        .o_complete        (o_complete)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_framing();
        term_run   = 2'd0;
        last_lf    = 1'b0;
        hdr_seen   = 1'b0;
        phase      = PH_KLEAD;
        key_pos    = 4'd0;
        neg_value  = 1'b0;
        len_acc    = 64'd0;
        len_status = ST_SEARCH;
        body_count = 64'd0;
    endfunction

    function automatic bit is_ws(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [7:0] fold(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic void settle_bad();
        len_status = ST_BAD;
        len_acc    = 64'd0;
        phase      = PH_DONE;
    endfunction

    function automatic void open_value();
        phase      = PH_VLEAD;
        len_status = ST_BAD;
        len_acc    = 64'd0;
    endfunction

    function automatic void take_digit(logic [7:0] c);
        logic [63:0] d;
        d = {56'd0, c - 8'h30};
        if (len_acc > (LEN_MAX - d) / 10) begin
            settle_bad();
        end else begin
            len_acc = len_acc * 10 + d;
            if (neg_value && len_acc != 64'd0) begin
                settle_bad();
            end else begin
                len_status = ST_VALID;
                phase      = PH_VDIG;
            end
        end
    endfunction

    function automatic t_framing advance_framing(logic [7:0] c, logic start);
        t_framing res;
        bit       ok;
        if (start)
            clear_framing();
        if (hdr_seen) begin
            if (body_count < LEN_MAX)
                body_count = body_count + 64'd1;
        end else begin
            if (phase != PH_DONE) begin
                if (c == LF_B) begin
                    if (phase >= PH_VLEAD) begin
                        phase = PH_DONE;
                    end else begin
                        phase   = PH_KLEAD;
                        key_pos = 4'd0;
                    end
                end else begin
                    case (phase)
                        PH_KLEAD: begin
                            if (!is_ws(c)) begin
                                if (c != ":" && fold(c) == key_word[0]) begin
                                    key_pos = 4'd1;
                                    phase   = PH_KEY;
                                end else begin
                                    phase = PH_SKIP;
                                end
                            end
                        end
                        PH_KEY: begin
                            if (c == ":") begin
                                if (key_pos == KEY_LEN)
                                    open_value();
                                else
                                    phase = PH_SKIP;
                            end else if (is_ws(c)) begin
                                phase = (key_pos == KEY_LEN) ? PH_KTAIL : PH_SKIP;
                            end else if (key_pos < KEY_LEN && fold(c) == key_word[key_pos]) begin
                                key_pos = key_pos + 4'd1;
                            end else begin
                                phase = PH_SKIP;
                            end
                        end
                        PH_KTAIL: begin
                            if (c == ":")
                                open_value();
                            else if (!is_ws(c))
                                phase = PH_SKIP;
                        end
                        PH_VLEAD: begin
                            if (!is_ws(c)) begin
                                if (c == "+" || c == "-") begin
                                    neg_value = (c == "-");
                                    phase     = PH_VSIGN;
                                end else if (is_digit(c)) begin
                                    take_digit(c);
                                end else begin
                                    settle_bad();
                                end
                            end
                        end
                        PH_VSIGN: begin
                            if (is_digit(c))
                                take_digit(c);
                            else
                                settle_bad();
                        end
                        PH_VDIG: begin
                            if (is_digit(c))
                                take_digit(c);
                            else
                                phase = PH_DONE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            if (c == CR_B) begin
                term_run = (term_run == 2'd2) ? 2'd3 : 2'd1;
            end else if (c == LF_B) begin
                if (term_run == 2'd3 || last_lf)
                    hdr_seen = 1'b1;
                term_run = (term_run == 2'd1) ? 2'd2 : 2'd0;
            end else begin
                term_run = 2'd0;
            end
            last_lf = (c == LF_B);
        end
        ok         = (len_status == ST_VALID);
        res.hdr    = hdr_seen;
        res.status = len_status;
        res.length = ok ? len_acc[31:0] : 32'd0;
        res.done   = hdr_seen && ok && (body_count >= len_acc);
        return res;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        t_text_beat t;
        t.data  = b;
        t.start = msg_head;
        byte_q  = {byte_q, t};
        msg_head = 1'b0;
    endtask

    task automatic push_text(input string s, input bit mix_case);
        logic [7:0] ch;
        for (int k = 0; k < s.len(); k++) begin
            ch = s[k];
            if (mix_case && ch >= "a" && ch <= "z" && $urandom_range(0, 1) == 1)
                ch = ch - 8'd32;
            push_byte(ch);
        end
    endtask

    task automatic push_break(input bit crlf);
        if (crlf)
            push_byte(CR_B);
        push_byte(LF_B);
    endtask

    task automatic push_space(input int n);
        repeat (n) begin
            case ($urandom_range(0, 4))
                0: push_byte(8'h09);
                1: push_byte(8'h0b);
                2: push_byte(8'h0c);
                3: push_byte(CR_B);
                default: push_byte(8'h20);
            endcase
        end
    endtask

    task automatic queue_message();
        int              lines;
        int              body_hint;
        int              body;
        bit              crlf;
        longint unsigned v;
        bit              has_digits;
        msg_head  = ($urandom_range(0, 9) != 0);
        crlf      = 1'($urandom_range(0, 1));
        lines     = $urandom_range(0, 3);
        body_hint = $urandom_range(0, 4);
        repeat (lines) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    case ($urandom_range(0, 3))
                        0: push_text("CSeq: 2", 1);
                        1: push_text("Session: 1a2b", 1);
                        2: push_text("Server: x", 1);
                        default: push_text("content-type: text", 1);
                    endcase
                end
                2: begin
                    case ($urandom_range(0, 4))
                        0: push_text("content-lengt: 5", 1);
                        1: push_text("content-lengthh: 5", 1);
                        2: push_text("content length: 5", 1);
                        3: push_text("xcontent-length: 5", 1);
                        default: push_text(":content-length: 5", 1);
                    endcase
                end
                3: begin
                    repeat ($urandom_range(1, 6))
                        push_byte(8'($urandom_range(0, 255)));
                end
                default: begin
                    push_space($urandom_range(0, 2));
                    push_text(key_word, 1);
                    push_space($urandom_range(0, 1));
                    push_byte(":");
                    push_space($urandom_range(0, 2));
                    case ($urandom_range(0, 5))
                        0: push_byte("+");
                        1: push_byte("-");
                        default: begin
                        end
                    endcase
                    has_digits = 1'b1;
                    case ($urandom_range(0, 9))
                        6: v = 64'd4294967295;
                        7: v = 64'd4294967296 + 64'($urandom_range(0, 1000));
                        8: v = {$urandom, $urandom};
                        9: has_digits = 1'b0;
                        default: v = 64'($urandom_range(0, 30));
                    endcase
                    if (has_digits) begin
                        if ($urandom_range(0, 4) == 0)
                            push_byte("0");
                        push_text($sformatf("%0d", v), 0);
                        if (v <= 40)
                            body_hint = int'(v);
                    end
                    repeat ($urandom_range(0, 2))
                        push_byte(8'($urandom_range(0, 255)));
                end
            endcase
            push_break(crlf);
        end
        if ($urandom_range(0, 7) != 0) begin
            push_break($urandom_range(0, 5) == 0 ? !crlf : crlf);
            if (lines == 0)
                push_break(crlf);
        end
        if ($urandom_range(0, 7) == 0)
            body = $urandom_range(0, body_hint);
        else
            body = body_hint + $urandom_range(0, 2);
        repeat (body)
            push_byte(8'($urandom_range(0, 255)));
    endtask

    // sender: advance to the next beat once the current one is taken
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_valid && !in_beat)) begin
            if (tx_wait != 0) begin
                tx_wait <= tx_wait - 1;
                i_valid <= 1'b0;
            end else if (byte_q.size() != 0) begin
                i_valid     <= 1'b1;
                i_data_byte <= byte_q[0].data;
                i_start_req <= byte_q[0].start;
                void'(byte_q.pop_front());
                if ($urandom_range(0, 39) == 0)
                    tx_calm <= !tx_calm;
                tx_wait <= tx_calm ? 0 : $urandom_range(0, 3);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: random waits per beat, one long hold to back up the input
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                i_ready   <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_ready   <= 1'b0;
            end else if (out_beat) begin
                rx_draw = rx_calm ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 39) == 0)
                    rx_calm <= !rx_calm;
                if (rx_draw == 0) begin
                    i_ready <= 1'b1;
                end else begin
                    i_ready <= 1'b0;
                    rx_wait <= rx_draw - 1;
                end
            end else if (rx_wait != 0) begin
                rx_wait <= rx_wait - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // monitor: check result beats, predict accepted input beats, watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_beat  <= i_valid && o_ready;
            out_beat <= o_valid && i_ready;
            if (o_valid && i_ready) begin
                got = {o_header_done, o_length_status, o_declared_length, o_complete};
                results_seen <= results_seen + 1;
                if (framing_q.size() == 0) begin
                    $display({"%0t: unexpected result: expected none, ",
                              "actual hdr=%0d status=%0d length=%0d complete=%0d"},
                             $time, got.hdr, got.status, got.length, got.done);
                    mismatch_count++;
                end else begin
                    want = framing_q.pop_front();
                    if (got !== want) begin
                        $display({"%0t: mismatch: expected hdr=%0d status=%0d length=%0d ",
                                  "complete=%0d, actual hdr=%0d status=%0d length=%0d ",
                                  "complete=%0d"},
                                 $time, want.hdr, want.status, want.length, want.done,
                                 got.hdr, got.status, got.length, got.done);
                        mismatch_count++;
                    end
                end
            end
            if (i_valid && o_ready)
                framing_q = {framing_q, advance_framing(i_data_byte, i_start_req)};
            if (byte_q.size() != 0 || i_valid || framing_q.size() != 0) begin
                if ((i_valid && o_ready) || (o_valid && i_ready))
                    idle_cycles = 0;
                else
                    idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    initial begin
        clear_framing();
        // bare LF LF header, no length, extreme payload bytes
        msg_head = 1'b1;
        push_break(1'b0);
        push_break(1'b0);
        push_byte(8'hff);
        push_byte(8'h00);
        // upper-case key, space before colon, negative zero, CRLF CRLF
        msg_head = 1'b1;
        push_text("CONTENT-LENGTH :-0", 0);
        push_break(1'b1);
        push_break(1'b1);
        push_byte("z");
        while (byte_q.size() < TARGET_BYTES)
            queue_message();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_q.size() != 0 || i_valid || framing_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/rmcd_pkg.sv
rtl/rmcd_front.sv
rtl/rmcd_queue.sv
rtl/rmcd_back.sv
rtl/rtsp_message_completeness_detector.sv
bench/testbench.sv
